@@ hdl/integer_to_radix_string_defines.svh @@
// integer_to_radix_string_defines.svh: assertion macros for the radix string converter
// used by the port checker; expects clk and rst_n in scope
`ifndef INTEGER_TO_RADIX_STRING_DEFINES_SVH
`define INTEGER_TO_RADIX_STRING_DEFINES_SVH

// same-cycle implication
`define I2RS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2RS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/i2rs_pkg.sv @@
// i2rs_pkg.sv: types, constants and the digit-to-character function of the radix string converter
// no dependencies
package i2rs_pkg;

  localparam int MAX_DIGITS = 64;
  localparam int ADDR_W     = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int VAL_W      = 63;
  localparam int NBITS_W    = 6;
  localparam int DIG_W      = 6;
  localparam int CHAR_W     = 7;

  localparam logic [5:0] RADIX_MIN     = 6'd2;
  localparam logic [5:0] RADIX_MAX     = 6'd36;
  localparam logic [6:0] MIN_LEN_LIMIT = 7'd64;
  localparam logic [6:0] ASCII_ZERO    = 7'h30;
  localparam logic [6:0] ASCII_A       = 7'h41;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NEG     = 2'd1,
    ST_BAD_RDX = 2'd2,
    ST_BAD_LEN = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [63:0] number;
    logic [5:0]         radix;
    logic [6:0]         min_chars;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    status_t           status;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic [NBITS_W-1:0] nbits;
    logic [VAL_W-1:0]   dividend;
  } div_ctl_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quot;
    logic [DIG_W-1:0] rem;
  } div_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < 6'd10) begin
      ch = ASCII_ZERO + CHAR_W'(d);
    end else if (d < RADIX_MAX) begin
      ch = ASCII_A + CHAR_W'(d - 6'd10);
    end else begin
      ch = ASCII_ZERO;
    end
    return ch;
  endfunction

endpackage

@@ hdl/integer_to_radix_string.sv @@
// an error result appears in the cycle after the transfer; otherwise each digit is one pass
// of the bit-serial divider over nbits bits (nbits 63 for the first digit, one less for each
// following one), then S_PAD or S_PRE, then S_EMIT: one character per cycle, padding first;
// one item per span; the divider loop sets the rate
// rst_n (synchronous) returns the sequencer to idle; the digit ram is not cleared
// results cannot be stalled: each is shown for one cycle with out_strobe
module integer_to_radix_string (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  i2rs_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output i2rs_pkg::out_item_t out_item
);
  import i2rs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_PAD  = 5'b00100,
    S_PRE  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [5:0]         radix_r, radix_nxt;
  logic [6:0]         min_len_r, min_len_nxt;
  logic [NBITS_W-1:0] nbits_r, nbits_nxt, nbits_dec;
  logic [CNT_W-1:0]   count_r, count_nxt, count_inc;
  logic [6:0]         pad_left_r, pad_left_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  out_item_t          out_item_r, out_item_nxt;

  div_ctl_t           div_ctl;
  div_sts_t           div_sts;
  logic               ram_we;
  logic [DIG_W-1:0]   rd_data;

  assign nbits_dec = (nbits_r > NBITS_W'(1)) ? nbits_r - NBITS_W'(1) : NBITS_W'(1);
  assign count_inc = count_r + CNT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    radix_nxt      = radix_r;
    min_len_nxt    = min_len_r;
    nbits_nxt      = nbits_r;
    count_nxt      = count_r;
    pad_left_nxt   = pad_left_r;
    addr_nxt       = addr_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    div_ctl.start    = 1'b0;
    div_ctl.nbits    = nbits_dec;
    div_ctl.dividend = div_sts.quot;
    ram_we         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_item_nxt.character = '0;
          out_item_nxt.last      = 1'b1;
          if (in_item.number[63]) begin
            out_strobe_nxt      = 1'b1;
            out_item_nxt.status = ST_NEG;
          end else if (in_item.radix < RADIX_MIN || in_item.radix > RADIX_MAX) begin
            out_strobe_nxt      = 1'b1;
            out_item_nxt.status = ST_BAD_RDX;
          end else if (in_item.min_chars > MIN_LEN_LIMIT) begin
            out_strobe_nxt      = 1'b1;
            out_item_nxt.status = ST_BAD_LEN;
          end else begin
            div_ctl.start    = 1'b1;
            div_ctl.nbits    = NBITS_W'(VAL_W);
            div_ctl.dividend = in_item.number[VAL_W-1:0];
            nbits_nxt        = NBITS_W'(VAL_W);
            radix_nxt        = in_item.radix;
            min_len_nxt      = in_item.min_chars;
            count_nxt        = '0;
            state_nxt        = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          ram_we    = 1'b1;
          count_nxt = count_inc;
          if (div_sts.quot != '0 && count_inc < CNT_W'(MAX_DIGITS)) begin
            div_ctl.start = 1'b1;
            nbits_nxt     = nbits_dec;
          end else begin
            addr_nxt = count_r[ADDR_W-1:0];
            if (min_len_r > 7'(count_inc)) begin
              pad_left_nxt = min_len_r - 7'(count_inc);
              state_nxt    = S_PAD;
            end else begin
              state_nxt = S_PRE;
            end
          end
        end
      end
      S_PAD: begin
        out_strobe_nxt         = 1'b1;
        out_item_nxt.character = ASCII_ZERO;
        out_item_nxt.last      = 1'b0;
        out_item_nxt.status    = ST_OK;
        pad_left_nxt           = pad_left_r - 7'd1;
        if (pad_left_r == 7'd1) begin
          addr_nxt  = addr_r - ADDR_W'(1);
          state_nxt = S_EMIT;
        end
      end
      S_PRE: begin
        addr_nxt  = addr_r - ADDR_W'(1);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_strobe_nxt         = 1'b1;
        out_item_nxt.character = digit_char(rd_data);
        out_item_nxt.last      = (count_r == CNT_W'(1));
        out_item_nxt.status    = ST_OK;
        count_nxt              = count_r - CNT_W'(1);
        addr_nxt               = addr_r - ADDR_W'(1);
        if (count_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
      count_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      count_r      <= count_nxt;
    end
    radix_r    <= radix_nxt;
    min_len_r  <= min_len_nxt;
    nbits_r    <= nbits_nxt;
    pad_left_r <= pad_left_nxt;
    addr_r     <= addr_nxt;
    out_item_r <= out_item_nxt;
  end

  i2rs_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (div_ctl),
    .divisor (radix_r),
    .sts     (div_sts)
  );

  i2rs_ram #(
    .WIDTH (DIG_W),
    .DEPTH (MAX_DIGITS)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (div_sts.rem),
    .raddr (addr_r),
    .rdata (rd_data)
  );

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

@@ hdl/i2rs_ram.sv @@
// i2rs_ram.sv: generic single-write, single-read ram with registered read data
// no dependencies
module i2rs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/i2rs_divider.sv @@
// i2rs_divider.sv: bit-serial restoring divider, one quotient bit per cycle
// depends on i2rs_pkg
module i2rs_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  i2rs_pkg::div_ctl_t        ctl,
  input  logic [i2rs_pkg::DIG_W-1:0] divisor,
  output i2rs_pkg::div_sts_t        sts
);
  import i2rs_pkg::*;

  logic [VAL_W-1:0]   dvd_r, dvd_nxt;
  logic [VAL_W-1:0]   quot_r, quot_nxt;
  logic [DIG_W-1:0]   rem_r, rem_nxt;
  logic [NBITS_W-1:0] idx_r, idx_nxt;
  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic [DIG_W:0]     trial;
  logic               fits;

  assign trial = {rem_r, dvd_r[idx_r]};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    dvd_nxt  = dvd_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    idx_nxt  = idx_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      dvd_nxt  = ctl.dividend;
      quot_nxt = '0;
      rem_nxt  = '0;
      idx_nxt  = ctl.nbits - NBITS_W'(1);
      run_nxt  = 1'b1;
    end else if (run_r) begin
      quot_nxt = {quot_r[VAL_W-2:0], fits};
      rem_nxt  = fits ? DIG_W'(trial - {1'b0, divisor}) : trial[DIG_W-1:0];
      idx_nxt  = idx_r - NBITS_W'(1);
      if (idx_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    dvd_r  <= dvd_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    idx_r  <= idx_nxt;
  end

  assign sts.done = done_r;
  assign sts.quot = quot_r;
  assign sts.rem  = rem_r;

endmodule

@@ hdl/i2rs_checker.sv @@
// i2rs_checker.sv: port-level checks of the radix string converter, bound to the top level
// depends on i2rs_pkg and integer_to_radix_string_defines.svh
`include "integer_to_radix_string_defines.svh"

module i2rs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input i2rs_pkg::in_item_t  in_item,
  input logic                out_strobe,
  input i2rs_pkg::out_item_t out_item
);
  import i2rs_pkg::*;

  logic accept, valid_args;

  assign accept     = start && !busy;
  assign valid_args = !in_item.number[63] && in_item.radix >= RADIX_MIN &&
                      in_item.radix <= RADIX_MAX && in_item.min_chars <= MIN_LEN_LIMIT;

  `I2RS_ASSERT_NOW(a_err_shape, out_strobe && out_item.status != ST_OK,
    out_item.character == '0 && out_item.last, "error result must be zero and last")

  `I2RS_ASSERT_NEXT(a_neg_err, accept && in_item.number[63],
    out_strobe && out_item.status == ST_NEG && !busy, "negative number not flagged")

  `I2RS_ASSERT_NEXT(a_valid_busy, accept && valid_args,
    busy && !out_strobe, "valid transfer did not start a conversion")

  `I2RS_ASSERT_NOW(a_last_idle, out_strobe && out_item.last && out_item.status == ST_OK,
    !busy, "still busy after final character")

endmodule

bind integer_to_radix_string i2rs_checker u_chk (.*);

@@ sim/integer_to_radix_string_test.sv @@
// integer_to_radix_string_test.sv: self-checking testbench for the radix string converter
// predicts every character of each accepted transfer and compares the strobed results
// depends on i2rs_pkg and integer_to_radix_string
`timescale 1ns / 100ps

module integer_to_radix_string_test;
  import i2rs_pkg::*;

  localparam string DIGIT_SET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

  class char_scoreboard;
    out_item_t expected_chars[$];
    int failures = 0;

    function void add_conversion(in_item_t item);
      logic [62:0] rest;
      logic [5:0] digits [0:63];
      int n;
      int total;
      out_item_t r;
      r.character = '0;
      r.last = 1'b1;
      if (item.number[63]) begin
        r.status = ST_NEG;
        expected_chars.push_back(r);
      end else if (item.radix < RADIX_MIN || item.radix > RADIX_MAX) begin
        r.status = ST_BAD_RDX;
        expected_chars.push_back(r);
      end else if (item.min_chars > MIN_LEN_LIMIT) begin
        r.status = ST_BAD_LEN;
        expected_chars.push_back(r);
      end else begin
        rest = item.number[62:0];
        n = 0;
        do begin
          digits[n] = 6'(rest % 63'(item.radix));
          n++;
          rest = rest / 63'(item.radix);
        end while (rest != 0 && n < MAX_DIGITS);
        total = (int'(item.min_chars) > n) ? int'(item.min_chars) : n;
        r.status = ST_OK;
        for (int k = 0; k < total; k++) begin
          if (k < total - n) begin
            r.character = ASCII_ZERO;
          end else begin
            r.character = 7'(DIGIT_SET[digits[total - 1 - k]]);
          end
          r.last = (k + 1 == total);
          expected_chars.push_back(r);
        end
      end
    endfunction

    function void check_char(out_item_t got);
      out_item_t exp;
      if (expected_chars.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: unexpected result char=%h last=%b status=%0d", $realtime,
                   got.character, got.last, got.status);
        end
      end else begin
        exp = expected_chars.pop_front();
        if (got.character !== exp.character || got.last !== exp.last ||
            got.status !== exp.status) begin
          failures++;
          if (failures <= 10) begin
            $display("%0t: mismatch exp char=%h last=%b status=%0d got char=%h last=%b status=%0d",
                     $realtime, exp.character, exp.last, exp.status,
                     got.character, got.last, got.status);
          end
        end
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_strobe;
  out_item_t out_item;

  char_scoreboard board = new();

  integer_to_radix_string uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      board.check_char(out_item);
    end
  end

  function automatic in_item_t make_item(logic [63:0] number, int radix, int min_chars);
    in_item_t item;
    item.number = number;
    item.radix = 6'(radix);
    item.min_chars = 7'(min_chars);
    return item;
  endfunction

  function automatic in_item_t random_item();
    in_item_t item;
    int kind;
    int w;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    kind = $urandom_range(99);
    w = $urandom_range(63);
    item.number = raw & ((64'd1 << w) - 64'd1);
    case ($urandom_range(9))
      0: item.radix = 6'd2;
      1: item.radix = 6'd36;
      default: item.radix = 6'($urandom_range(36, 2));
    endcase
    case ($urandom_range(9))
      0: item.min_chars = 7'd0;
      1: item.min_chars = 7'd64;
      default: item.min_chars = 7'($urandom_range(64, 0));
    endcase
    if (kind < 6) begin
      item.number = raw | (64'd1 << 63);
    end else if (kind < 11) begin
      item.radix = $urandom_range(1) ? 6'($urandom_range(1)) : 6'($urandom_range(63, 37));
    end else if (kind < 15) begin
      item.min_chars = 7'($urandom_range(127, 65));
    end
    return item;
  endfunction

  task automatic idle_cycle();
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic send_item(input in_item_t item, input int idle_pct);
    while ($urandom_range(99) < idle_pct) idle_cycle();
    @(negedge clk);
    start = 1'b1;
    in_item = item;
    do @(posedge clk); while (busy);
    board.add_conversion(item);
  endtask

  task automatic drain();
    idle_cycle();
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int idle_pct [4];
    logic [63:0] max_pos;
    idle_pct = '{0, 66, 0, 32};
    max_pos = 64'h7FFF_FFFF_FFFF_FFFF;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero, extremes of length and radix, padding around the digit count
    send_item(make_item(64'd0, 10, 0), 0);
    send_item(make_item(64'd0, 2, 64), 0);
    send_item(make_item(max_pos, 2, 0), 0);
    send_item(make_item(max_pos, 2, 64), 0);
    send_item(make_item(max_pos, 36, 64), 0);
    send_item(make_item(max_pos, 16, 0), 0);
    send_item(make_item(64'd35, 36, 0), 0);
    send_item(make_item(64'd1295, 36, 1), 0);
    send_item(make_item(64'd12345, 10, 3), 0);
    send_item(make_item(64'd12345, 10, 5), 0);
    send_item(make_item(64'd12345, 10, 8), 0);
    send_item(make_item(64'd1, 3, 63), 0);
    // error checks and their order
    send_item(make_item(64'hFFFF_FFFF_FFFF_FFFF, 10, 0), 0);
    send_item(make_item(64'h8000_0000_0000_0000, 2, 64), 0);
    send_item(make_item(64'h8000_0000_0000_0001, 0, 127), 0);
    send_item(make_item(64'd7, 0, 0), 0);
    send_item(make_item(64'd7, 1, 0), 0);
    send_item(make_item(64'd7, 37, 0), 0);
    send_item(make_item(64'd7, 63, 127), 0);
    send_item(make_item(64'd7, 10, 65), 0);
    send_item(make_item(max_pos, 36, 127), 0);
    drain();

    foreach (idle_pct[p]) begin
      repeat (90) send_item(random_item(), idle_pct[p]);
      drain();
    end

    repeat (200) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ integer_to_radix_string.f @@
+incdir+hdl
hdl/i2rs_pkg.sv
hdl/i2rs_ram.sv
hdl/i2rs_divider.sv
hdl/integer_to_radix_string.sv
hdl/i2rs_checker.sv
sim/integer_to_radix_string_test.sv
